### src/cfabln_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfabln_pkg: shared constants and types for the CFA black level normalizer
// Register indexes, reset values, parameter defaults and the datapath mode.
// ----------------------------------------------------------------------------
package cfabln_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CFA_MAP_W   = 8;
  localparam int NUM_CH      = 4;

  localparam logic [CFA_MAP_W-1:0]  CFA_MAP_RST = 8'd228;
  localparam logic [CFG_DATA_W-1:0] WHITE_RST   = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CFA_MAP   = 3'd0,
    REG_BLACK_CH0 = 3'd1,
    REG_BLACK_CH1 = 3'd2,
    REG_BLACK_CH2 = 3'd3,
    REG_BLACK_CH3 = 3'd4,
    REG_WHITE     = 3'd5
  } cfg_reg_t;

  // What the final stage does with the quotient
  typedef enum logic [1:0] {
    MODE_DIV  = 2'd0,
    MODE_ZERO = 2'd1,
    MODE_ONE  = 2'd2,
    MODE_NEED = 2'd3
  } mode_t;

endpackage
`default_nettype wire

### src/cfa_black_level_normalize_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_black_level_normalize_unit: raw Bayer black/white level normalizer
// Picks the channel black level from the CFA position, then returns
// (pixel - black) / (white - black) clamped to [0,1] as unsigned Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in_       slave      tvalid/tready      tdata: pixel; tuser: col_odd, row_odd
// out_      master     tvalid/tready      tdata: level; tuser: status
// cfg_      slave      valid/ready        index, data (register write)
//
// One pixel per cycle sustained while out_tready stays high. Stages: channel
// select, compare/subtract, then one restoring-division stage per quotient bit.
// Reset (rst_n low, synchronous) clears all valid bits and loads register
// reset values. Each stage holds while its successor is full and stalled, so
// bubbles collapse and in_tready only drops once the whole pipe is full.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module cfa_black_level_normalize_unit #(
  parameter int PIXEL_BITS = cfabln_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = cfabln_pkg::FRAC_BITS_DEF,
  localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int LEVEL_W     = FRAC_BITS + 1,
  localparam int OUT_TDATA_W = ((LEVEL_W + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [IN_TDATA_W-1:0]              in_tdata,   // [PIXEL_BITS-1:0] pixel
  input  wire logic [1:0]                         in_tuser,   // [0] col_odd, [1] row_odd

  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [OUT_TDATA_W-1:0]                  out_tdata,  // [FRAC_BITS:0] level
  output logic                                    out_tuser,  // [0] status

  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cfabln_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cfabln_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // ---------------- configuration registers ----------------
  logic [cfabln_pkg::CFA_MAP_W-1:0] cfa_map_r;
  logic [PIXEL_BITS-1:0]            black_r [cfabln_pkg::NUM_CH];
  logic [PIXEL_BITS-1:0]            white_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfa_map_r <= cfabln_pkg::CFA_MAP_RST;
      white_r   <= PIXEL_BITS'(cfabln_pkg::WHITE_RST);
      for (int i = 0; i < cfabln_pkg::NUM_CH; i++) begin
        black_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfabln_pkg::REG_CFA_MAP:   cfa_map_r  <= cfg_data[cfabln_pkg::CFA_MAP_W-1:0];
        cfabln_pkg::REG_BLACK_CH0: black_r[0] <= PIXEL_BITS'(cfg_data);
        cfabln_pkg::REG_BLACK_CH1: black_r[1] <= PIXEL_BITS'(cfg_data);
        cfabln_pkg::REG_BLACK_CH2: black_r[2] <= PIXEL_BITS'(cfg_data);
        cfabln_pkg::REG_BLACK_CH3: black_r[3] <= PIXEL_BITS'(cfg_data);
        cfabln_pkg::REG_WHITE:     white_r    <= PIXEL_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  logic                 s0_vld_r, s1_vld_r;
  logic [FRAC_BITS-1:0] dv_vld_r;
  logic                 s0_adv, s1_adv;
  logic [FRAC_BITS-1:0] dv_adv;

  always_comb begin
    dv_adv[FRAC_BITS-1] = !dv_vld_r[FRAC_BITS-1] || out_tready;
    for (int k = FRAC_BITS - 2; k >= 0; k--) begin
      dv_adv[k] = !dv_vld_r[k] || dv_adv[k+1];
    end
    s1_adv = !s1_vld_r || dv_adv[0];
    s0_adv = !s0_vld_r || s1_adv;
  end

  assign in_tready = s0_adv;

  // ---------------- stage 0: channel select ----------------
  logic [PIXEL_BITS-1:0]            s0_pix_r, s0_blk_r;
  logic [1:0]                       in_pos;
  logic [cfabln_pkg::CFA_MAP_W-1:0] map_sh;
  logic [1:0]                       in_ch;

  always_comb begin
    in_pos = {in_tuser[1], in_tuser[0]};
    map_sh = cfa_map_r >> {in_pos, 1'b0};
    in_ch  = map_sh[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_adv) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s0_pix_r <= in_tdata[PIXEL_BITS-1:0];
      s0_blk_r <= black_r[in_ch];
    end
  end

  // ---------------- stage 1: compare and subtract ----------------
  logic [PIXEL_BITS-1:0] s1_num_r, s1_den_r;
  cfabln_pkg::mode_t     s1_mode_r;
  cfabln_pkg::mode_t     s1_mode_nxt;

  always_comb begin
    if (white_r <= s0_blk_r) begin
      s1_mode_nxt = cfabln_pkg::MODE_NEED;
    end else if (s0_pix_r <= s0_blk_r) begin
      s1_mode_nxt = cfabln_pkg::MODE_ZERO;
    end else if (s0_pix_r >= white_r) begin
      s1_mode_nxt = cfabln_pkg::MODE_ONE;
    end else begin
      s1_mode_nxt = cfabln_pkg::MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_mode_r <= s1_mode_nxt;
      s1_num_r  <= s0_pix_r - s0_blk_r;
      s1_den_r  <= white_r - s0_blk_r;
    end
  end

  // ---------------- restoring division, one quotient bit per stage ----------
  // num < den on the divide path, so the remainder fits PIXEL_BITS bits and
  // the quotient fits FRAC_BITS bits.
  logic [PIXEL_BITS-1:0] dv_rem_r  [FRAC_BITS];
  logic [PIXEL_BITS-1:0] dv_den_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0]  dv_q_r    [FRAC_BITS];
  cfabln_pkg::mode_t     dv_mode_r [FRAC_BITS];

  logic [PIXEL_BITS-1:0] dv_rem_nxt [FRAC_BITS];
  logic [FRAC_BITS-1:0]  dv_q_nxt   [FRAC_BITS];
  logic [PIXEL_BITS-1:0] src_rem    [FRAC_BITS];
  logic [PIXEL_BITS-1:0] src_den    [FRAC_BITS];
  logic [FRAC_BITS-1:0]  src_q      [FRAC_BITS];
  logic [PIXEL_BITS:0]   shl        [FRAC_BITS];
  logic [PIXEL_BITS:0]   diff       [FRAC_BITS];

  always_comb begin
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (k == 0) begin
        src_rem[k] = s1_num_r;
        src_den[k] = s1_den_r;
        src_q[k]   = '0;
      end else begin
        src_rem[k] = dv_rem_r[k-1];
        src_den[k] = dv_den_r[k-1];
        src_q[k]   = dv_q_r[k-1];
      end
      shl[k]  = {src_rem[k], 1'b0};
      diff[k] = shl[k] - {1'b0, src_den[k]};
      if (!diff[k][PIXEL_BITS]) begin
        dv_rem_nxt[k] = diff[k][PIXEL_BITS-1:0];
        dv_q_nxt[k]   = {src_q[k][FRAC_BITS-2:0], 1'b1};
      end else begin
        dv_rem_nxt[k] = shl[k][PIXEL_BITS-1:0];
        dv_q_nxt[k]   = {src_q[k][FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else begin
      for (int k = 0; k < FRAC_BITS; k++) begin
        if (dv_adv[k]) begin
          dv_vld_r[k] <= (k == 0) ? s1_vld_r : dv_vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (dv_adv[k]) begin
        dv_rem_r[k]  <= dv_rem_nxt[k];
        dv_q_r[k]    <= dv_q_nxt[k];
        dv_den_r[k]  <= src_den[k];
        dv_mode_r[k] <= (k == 0) ? s1_mode_r : dv_mode_r[k-1];
      end
    end
  end

  // ---------------- output ----------------
  logic [LEVEL_W-1:0] out_level;

  always_comb begin
    case (dv_mode_r[FRAC_BITS-1])
      cfabln_pkg::MODE_DIV: out_level = {1'b0, dv_q_r[FRAC_BITS-1]};
      cfabln_pkg::MODE_ONE: out_level = {1'b1, {FRAC_BITS{1'b0}}};
      default:              out_level = '0;
    endcase
  end

  assign out_tvalid = dv_vld_r[FRAC_BITS-1];
  assign out_tdata  = OUT_TDATA_W'(out_level);
  assign out_tuser  = (dv_mode_r[FRAC_BITS-1] == cfabln_pkg::MODE_NEED);

endmodule
`default_nettype wire
